FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, included by the classifier unit
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

FILE: src/gbsc_pkg.sv
// ----------------------------------------------------------------------------
// gbsc_pkg
// types, constants and helper functions of the bearing steer classifier
// ----------------------------------------------------------------------------
package gbsc_pkg;

    localparam int CORDIC_STEPS = 24;

    // register count of each pipeline section; LAT adds the bearing and output registers
    localparam int LAT_CNV = 4;
    localparam int LAT_SC  = CORDIC_STEPS + 2;
    localparam int LAT_MUL = 3;
    localparam int LAT_AT  = CORDIC_STEPS + 1;
    localparam int LAT     = LAT_CNV + LAT_SC + LAT_MUL + LAT_AT + 2;

    localparam int ADDR_W = 3;

    localparam logic REG_TLAT = 1'b0;
    localparam logic REG_TLON = 1'b1;

    localparam logic [15:0] TURN_UNITS = 16'd46080;
    localparam logic [15:0] LIM_FWD_LO   = 16'd1280;
    localparam logic [15:0] LIM_SOFT_HI  = 16'd11520;
    localparam logic [15:0] LIM_HARD_HI  = 16'd23040;
    localparam logic [15:0] LIM_RHARD_HI = 16'd34560;
    localparam logic [15:0] LIM_FWD_HI   = 16'd44800;

    // degree to binary angle: offset keeps the dividend positive, 45 * 2^26
    localparam logic [33:0] BAM_OFFSET = 34'd3019898880;
    // floor(2^37 / 45)
    localparam logic [31:0] BAM_RECIP  = 32'd3054198966;

    localparam logic signed [31:0] CORDIC_KQ30 = 32'sh26DD3B6A;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        STEER_FWD        = 3'd0,
        STEER_SOFT_LEFT  = 3'd1,
        STEER_HARD_LEFT  = 3'd2,
        STEER_SOFT_RIGHT = 3'd3,
        STEER_HARD_RIGHT = 3'd4
    } t_steer;

    typedef logic signed [31:0] t_q30;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic [15:0]        heading;
    } t_in_word;

    typedef struct packed {
        logic [15:0] bearing;
        logic [15:0] heading_error;
        logic [2:0]  steer_class;
    } t_out_word;

    // low six bits of the binary angle: floor((64*r + 22) / 45) for r < 45
    function automatic logic [5:0] bam_frac(input logic [5:0] r);
        logic [11:0] num;
        logic [23:0] prod;
        num  = {r, 6'd0} + 12'd22;
        prod = 24'(num) * 24'd2913;
        return prod[22:17];
    endfunction

    function automatic t_steer steer_of(input logic [15:0] e);
        t_steer c;
        if (e < LIM_FWD_LO || e >= LIM_FWD_HI) begin
            c = STEER_FWD;
        end else if (e < LIM_SOFT_HI) begin
            c = STEER_SOFT_LEFT;
        end else if (e < LIM_HARD_HI) begin
            c = STEER_HARD_LEFT;
        end else if (e < LIM_RHARD_HI) begin
            c = STEER_HARD_RIGHT;
        end else begin
            c = STEER_SOFT_RIGHT;
        end
        return c;
    endfunction

endpackage

FILE: src/gbsc_sincos.sv
// ----------------------------------------------------------------------------
// gbsc_sincos
// pipelined rotation cordic, one iteration per stage, q30 sine and cosine
// ----------------------------------------------------------------------------
module gbsc_sincos (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [31:0]   i_angle,
    output gbsc_pkg::t_q30 o_cos,
    output gbsc_pkg::t_q30 o_sin
);
    import gbsc_pkg::*;

    logic signed [31:0] r_x [CORDIC_STEPS+1];
    logic signed [31:0] r_y [CORDIC_STEPS+1];
    logic signed [31:0] r_z [CORDIC_STEPS+1];
    logic               r_neg [CORDIC_STEPS+1];
    logic signed [31:0] r_cos;
    logic signed [31:0] r_sin;

    logic [31:0] n_turn;
    logic [31:0] n_a;
    logic        n_neg;

    // fold second and third quadrant by half a turn
    always_comb begin
        n_turn = i_angle + 32'h4000_0000;
        n_neg  = n_turn[31];
        n_a    = n_neg ? (i_angle + 32'h8000_0000) : i_angle;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= CORDIC_KQ30;
            r_y[0]   <= '0;
            r_z[0]   <= signed'(n_a);
            r_neg[0] <= n_neg;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [31:0] n_x;
        logic signed [31:0] n_y;
        logic signed [31:0] n_z;

        always_comb begin
            if (r_z[i] >= 0) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - signed'(ATAN_TAB[i]);
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + signed'(ATAN_TAB[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_neg[i+1] <= r_neg[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            r_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

FILE: src/gbsc_atan2.sv
// ----------------------------------------------------------------------------
// gbsc_atan2
// pipelined vectoring cordic, binary angle of a vector, one step per stage
// ----------------------------------------------------------------------------
module gbsc_atan2 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_x,
    input  logic signed [33:0] i_y,
    output logic [31:0]        o_angle
);
    import gbsc_pkg::*;

    logic signed [35:0] r_vx [CORDIC_STEPS+1];
    logic signed [35:0] r_vy [CORDIC_STEPS+1];
    logic [31:0]        r_z  [CORDIC_STEPS+1];
    logic               r_zero [CORDIC_STEPS+1];

    logic signed [35:0] n_x;
    logic signed [35:0] n_y;

    always_comb begin
        n_x = 36'(i_x);
        n_y = 36'(i_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_vx[0] <= -n_x;
                r_vy[0] <= -n_y;
                r_z[0]  <= 32'h8000_0000;
            end else begin
                r_vx[0] <= n_x;
                r_vy[0] <= n_y;
                r_z[0]  <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [35:0] n_vx;
        logic signed [35:0] n_vy;
        logic [31:0]        n_z;

        always_comb begin
            if (r_vy[i] >= 0) begin
                n_vx = r_vx[i] + (r_vy[i] >>> i);
                n_vy = r_vy[i] - (r_vx[i] >>> i);
                n_z  = r_z[i] + ATAN_TAB[i];
            end else begin
                n_vx = r_vx[i] - (r_vy[i] >>> i);
                n_vy = r_vy[i] + (r_vx[i] >>> i);
                n_z  = r_z[i] - ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vx[i+1]   <= n_vx;
                r_vy[i+1]   <= n_vy;
                r_z[i+1]    <= n_z;
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    assign o_angle = r_zero[CORDIC_STEPS] ? '0 : r_z[CORDIC_STEPS];

endmodule

FILE: src/gps_bearing_steer_classifier_unit.sv
// ----------------------------------------------------------------------------
// gps_bearing_steer_classifier_unit
// great-circle initial bearing to a programmed target and steering class
// ----------------------------------------------------------------------------
//
//  port group        | direction | handshake            | content
//  ------------------+-----------+----------------------+------------------------
//  i_data            | in        | i_valid / o_ready    | latitude, longitude, heading
//  o_data            | out       | o_valid / i_ready    | bearing, error, steer class
//  psel ... prdata   | in/out    | apb, pready tied high| target latitude, longitude
//
//  one word enters per cycle unless the pipeline stalls; the cordic sections
//  run one cordic iteration per pipeline stage
//  the whole pipeline advances together; it stalls only when the output
//  register holds a word that is not taken
//  synchronous active-low reset clears the valid chain and the target registers
//
module gps_bearing_steer_classifier_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  gbsc_pkg::t_in_word              i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output gbsc_pkg::t_out_word             o_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbsc_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import gbsc_pkg::*;

    `include "assert_macros.svh"

    // ---------------- configuration ----------------
    logic signed [30:0] r_tlat;
    logic signed [31:0] r_tlon;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlat <= '0;
            r_tlon <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_TLAT: r_tlat <= pwdata[30:0];
                REG_TLON: r_tlon <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TLAT: prdata = {1'b0, r_tlat};
            REG_TLON: prdata = r_tlon;
            default:  prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // every stage moves together; the output register frees the pipe when taken
    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en    = !r_vld[LAT-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // heading rides along until the error stage
    logic [15:0] r_hd [LAT-1];
    logic [15:0] n_hd;

    assign n_hd = (i_data.heading >= TURN_UNITS) ? (i_data.heading - TURN_UNITS)
                                                 : i_data.heading;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hd[0] <= n_hd;
        end
    end

    for (genvar k = 1; k < LAT - 1; k++) begin : g_hd
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_hd[k] <= r_hd[k-1];
            end
        end
    end

    // ---------------- degrees to binary angle ----------------
    // q = floor((64v + 22) / 45); v = 45t + u gives q = 64t + floor((64u + 22) / 45)
    // t comes from a reciprocal multiply with one correction step;
    // the offset 45 * 2^26 keeps the dividend positive and drops out mod 2^32
    // lanes: lat, lon, target lat, target lon
    logic signed [31:0] w_deg [4];

    assign w_deg[0] = 32'(i_data.latitude);
    assign w_deg[1] = i_data.longitude;
    assign w_deg[2] = 32'(r_tlat);
    assign w_deg[3] = r_tlon;

    logic [31:0] w_bam [4];

    for (genvar j = 0; j < 4; j++) begin : g_cnv
        logic [32:0] r_w1;
        logic [32:0] r_w2;
        logic [27:0] r_test;
        logic [25:0] r_t;
        logic [5:0]  r_r;
        logic [33:0] n_w;
        logic [64:0] n_prod;
        logic [33:0] n_rem;
        logic [6:0]  n_r0;

        assign n_w    = 34'(w_deg[j]) + BAM_OFFSET;
        assign n_prod = 65'(r_w1) * 65'(BAM_RECIP);
        assign n_rem  = 34'(r_w2) - (34'(r_test) * 34'd45);
        assign n_r0   = n_rem[6:0];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_w1   <= n_w[32:0];
                r_w2   <= r_w1;
                r_test <= n_prod[64:37];
                if (n_r0 >= 7'd45) begin
                    r_t <= r_test[25:0] + 26'd1;
                    r_r <= 6'(n_r0 - 7'd45);
                end else begin
                    r_t <= r_test[25:0];
                    r_r <= n_r0[5:0];
                end
            end
        end

        assign w_bam[j] = {r_t, bam_frac(r_r)};
    end

    logic [31:0] r_la;
    logic [31:0] r_ta;
    logic [31:0] r_dl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_la <= w_bam[0];
            r_ta <= w_bam[2];
            r_dl <= w_bam[3] - w_bam[1];
        end
    end

    // ---------------- sine and cosine ----------------
    t_q30 w_cl, w_sl, w_ct, w_st, w_cd, w_sd;

    gbsc_sincos u_sc_lat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_la),
        .o_cos   (w_cl),
        .o_sin   (w_sl)
    );

    gbsc_sincos u_sc_tlat (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_ta),
        .o_cos   (w_ct),
        .o_sin   (w_st)
    );

    gbsc_sincos u_sc_dlon (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r_dl),
        .o_cos   (w_cd),
        .o_sin   (w_sd)
    );

    // ---------------- spherical products ----------------
    // X = ct*sd, Y = cl*st - (sl*ct)*cd, every product scaled back by 2^30
    logic signed [63:0] n_px;
    logic signed [63:0] n_p1;
    logic signed [63:0] n_p2;
    logic signed [65:0] n_p3;
    logic signed [33:0] r_x1, r_p1, r_p2, r_x2, r_q1, r_p3, r_x3, r_y3;
    logic signed [31:0] r_cd1;
    logic signed [34:0] n_y;

    assign n_px = w_ct * w_sd;
    assign n_p1 = w_cl * w_st;
    assign n_p2 = w_sl * w_ct;
    assign n_p3 = 66'(r_p2) * 66'(r_cd1);
    assign n_y  = 35'(r_q1) - 35'(r_p3);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1  <= n_px[63:30];
            r_p1  <= n_p1[63:30];
            r_p2  <= n_p2[63:30];
            r_cd1 <= w_cd;
            r_x2  <= r_x1;
            r_q1  <= r_p1;
            r_p3  <= n_p3[63:30];
            r_x3  <= r_x2;
            r_y3  <= n_y[33:0];
        end
    end

    // ---------------- bearing angle ----------------
    logic [31:0] w_ang;

    gbsc_atan2 u_atan2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_x     (r_y3),
        .i_y     (r_x3),
        .o_angle (w_ang)
    );

    // binary angle to 1/128 degree, rounded to nearest
    logic [47:0] n_brp;
    logic [15:0] r_brr;

    assign n_brp = (48'(w_ang) * 48'(TURN_UNITS)) + 48'h0000_8000_0000;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_brr <= n_brp[47:32];
        end
    end

    // ---------------- heading error and class ----------------
    logic [15:0] n_br;
    logic [16:0] n_e0;
    logic [15:0] n_err;
    t_out_word   n_out;
    t_out_word   r_out;

    always_comb begin
        n_br  = (r_brr >= TURN_UNITS) ? '0 : r_brr;
        n_e0  = 17'(n_br) + 17'(TURN_UNITS) - 17'(r_hd[LAT-2]);
        n_err = (n_e0 >= 17'(TURN_UNITS)) ? 16'(n_e0 - 17'(TURN_UNITS)) : n_e0[15:0];
        n_out.bearing       = n_br;
        n_out.heading_error = n_err;
        n_out.steer_class   = steer_of(n_err);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ---------------- checks ----------------
    `ASSERT_HOLDS(a_accept_enters, i_clk, i_rst_n, (i_valid && o_ready) |=> r_vld[0])
    `ASSERT_HOLDS(a_stall_freezes, i_clk, i_rst_n, !w_en |=> $stable(r_vld))
    `ASSERT_NEVER(a_out_range, i_clk, i_rst_n,
                  o_valid && (o_data.bearing >= TURN_UNITS
                              || o_data.heading_error >= TURN_UNITS))
    `ASSERT_NEVER(a_fwd_class, i_clk, i_rst_n,
                  o_valid && o_data.heading_error < LIM_FWD_LO
                  && o_data.steer_class != STEER_FWD)

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks bearing, heading error and steer class of the bearing steer
// classifier against a bit-exact fixed-point cordic predictor, under random
// sender gaps, receiver stalls and several target settings
// ----------------------------------------------------------------------------
module testbench;
    import gbsc_pkg::*;

    // full-range coordinate limits in 2^-23 degree units
    localparam int LAT_MAX = 754974720;
    localparam int LON_MAX = 1509949440;
    localparam int HDG_MAX = 46079;
    localparam int APB_TLAT = 0;   // byte address of target latitude
    localparam int APB_TLON = 4;   // byte address of target longitude
    localparam int DRAIN_CYCLES = 70;  // a little over the pipeline depth
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in_word i_data;
    logic o_valid;
    logic i_ready;
    t_out_word o_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    gps_bearing_steer_classifier_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor copy of the target registers
    logic signed [30:0] tgt_lat;
    logic signed [31:0] tgt_lon;

    // expected result words, oldest first
    t_out_word bearing_q[$];

    int mismatches;
    int idle_cycles;
    bit no_idle;    // when set both sides run without gaps or stalls

    // ------------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------------

    // degrees in 2^-23 units to 32-bit binary angle, v*64/45 rounded half up
    function automatic logic [31:0] deg_to_bam(input longint v);
        longint n;
        longint q;
        n = v * 128 + 45;
        if (n >= 0) begin
            q = n / 90;
        end else begin
            q = -((-n + 89) / 90);
        end
        return q[31:0];
    endfunction

    // rotation cordic, left half-plane angles folded by 180 degrees
    function automatic void rotate_sincos(input logic [31:0] a,
                                          output longint c, output longint s);
        logic [31:0] sum;
        logic [31:0] af;
        bit neg;
        longint x, y, z, dx, dy;
        sum = a + 32'h40000000;
        neg = sum[31];
        af = neg ? a + 32'h80000000 : a;
        x = CORDIC_KQ30;
        y = 0;
        z = longint'($signed(af));
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
            end else begin
                x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    // vectoring cordic, angle of (vx, vy) as a binary angle
    function automatic logic [31:0] vector_angle(input longint vx, input longint vy);
        logic [31:0] z;
        longint dx, dy;
        z = 32'd0;
        if (vx == 0 && vy == 0) begin
            return 32'd0;
        end
        if (vx < 0) begin
            vx = -vx; vy = -vy; z = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx = vx + dx; vy = vy - dy; z = z + ATAN_TAB[i];
            end else begin
                vx = vx - dx; vy = vy + dy; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic t_out_word predict_steer(input t_in_word w);
        t_out_word r;
        logic [31:0] la, ta, dl, ang;
        longint cl, sl, ct, st, cd, sd, xe, yn;
        logic [63:0] wide;
        int unsigned hd, br, err;
        hd = int'(w.heading) % 46080;
        la = deg_to_bam(longint'(w.latitude));
        ta = deg_to_bam(longint'(tgt_lat));
        dl = deg_to_bam(longint'(tgt_lon)) - deg_to_bam(longint'(w.longitude));
        rotate_sincos(la, cl, sl);
        rotate_sincos(ta, ct, st);
        rotate_sincos(dl, cd, sd);
        xe = (ct * sd) >>> 30;
        yn = ((cl * st) >>> 30) - ((((sl * ct) >>> 30) * cd) >>> 30);
        ang = vector_angle(yn, xe);
        wide = {32'd0, ang} * 64'd46080 + 64'h80000000;
        br = wide[63:32];
        if (br >= 46080) begin
            br = 0;
        end
        err = (br + 46080 - hd) % 46080;
        r.bearing = br[15:0];
        r.heading_error = err[15:0];
        if (err < LIM_FWD_LO || err >= LIM_FWD_HI) begin
            r.steer_class = STEER_FWD;
        end else if (err < LIM_SOFT_HI) begin
            r.steer_class = STEER_SOFT_LEFT;
        end else if (err < LIM_HARD_HI) begin
            r.steer_class = STEER_HARD_LEFT;
        end else if (err < LIM_RHARD_HI) begin
            r.steer_class = STEER_HARD_RIGHT;
        end else begin
            r.steer_class = STEER_SOFT_RIGHT;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // clock, reset, watchdog
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // any accepted word on either side resets the idle count
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall per word, compare at the accepting edge
    // ------------------------------------------------------------------------

    initial begin : result_checker
        t_out_word want;
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                i_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (bearing_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word %h", o_data);
                end
            end else begin
                want = bearing_q.pop_front();
                if (o_data.bearing !== want.bearing
                    || o_data.heading_error !== want.heading_error
                    || o_data.steer_class !== want.steer_class) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: bearing %0d/%0d error %0d/%0d class %0d/%0d",
                                 want.bearing, o_data.bearing,
                                 want.heading_error, o_data.heading_error,
                                 want.steer_class, o_data.steer_class);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared tasks
    // ------------------------------------------------------------------------

    // one fix into the block; valid stays up afterwards until the next call
    task automatic send_fix(input t_in_word w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_data = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        bearing_q.push_back(predict_steer(w));
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid = 1'b0;
        while (bearing_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // apb write, setup then access; only called with the pipeline empty
    task automatic write_target(input int addr, input logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr[ADDR_W-1:0];
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (addr == APB_TLAT) begin
            tgt_lat = value[30:0];
        end else begin
            tgt_lon = value;
        end
    endtask

    task automatic set_target(input int lat, input int lon);
        drain();
        write_target(APB_TLAT, lat);
        write_target(APB_TLON, lon);
    endtask

    function automatic t_in_word make_fix(input int lat, input int lon, input int hdg);
        t_in_word w;
        w.latitude = lat[30:0];
        w.longitude = lon;
        w.heading = hdg[15:0];
        return w;
    endfunction

    // mostly in range, sometimes raw bits so every bit toggles
    function automatic t_in_word random_fix;
        t_in_word w;
        int lat, lon, hdg;
        lat = $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
        lon = int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
        hdg = $urandom_range(0, HDG_MAX);
        if ($urandom_range(0, 9) == 0) lat = $urandom;
        if ($urandom_range(0, 9) == 0) lon = $urandom;
        if ($urandom_range(0, 9) == 0) hdg = $urandom_range(0, 65535);
        w = make_fix(lat, lon, hdg);
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // field extremes, coincident and polar points, all headings of interest
    task automatic test_directed;
        set_target(0, 0);
        send_fix(make_fix(0, 0, 0));                    // coincident points
        send_fix(make_fix(LAT_MAX, 0, 100));            // current at north pole
        send_fix(make_fix(-LAT_MAX, LON_MAX, HDG_MAX));
        send_fix(make_fix(LAT_MAX, -LON_MAX, 46080));   // heading just out of range
        send_fix(make_fix(-LAT_MAX, -LON_MAX, 65535));
        send_fix(make_fix(0, LON_MAX, 0));
        send_fix(make_fix(0, -LON_MAX, 0));
        send_fix(make_fix(-1, 1, 1));
        send_fix(make_fix(32'h40000000, 32'h7FFFFFFF, 0));  // raw extremes
        send_fix(make_fix(32'hC0000000, 32'h80000000, 0));
        // due east, headings spread over the steer classes and their boundaries
        send_fix(make_fix(0, -8388608, 11520));
        send_fix(make_fix(0, -8388608, 10241));
        send_fix(make_fix(0, -8388608, 0));
        send_fix(make_fix(0, -8388608, 34560));
        send_fix(make_fix(0, -8388608, 22000));
        send_fix(make_fix(0, -8388608, 44000));
        send_fix(make_fix(0, -8388608, 12799));
        // target at a pole
        set_target(LAT_MAX, 0);
        send_fix(make_fix(LAT_MAX, 0, 0));
        send_fix(make_fix(0, 12345678, 300));
        send_fix(make_fix(-LAT_MAX, LON_MAX, 0));
    endtask

    // extreme and random target settings, each with a batch of fixes
    task automatic test_targets;
        int lats[4] = '{-LAT_MAX, LAT_MAX, 0, -LAT_MAX};
        int lons[4] = '{LON_MAX, -LON_MAX, LON_MAX, -LON_MAX};
        for (int k = 0; k < 4; k++) begin
            set_target(lats[k], lons[k]);
            repeat (40) send_fix(random_fix());
        end
        // raw bits into both registers
        set_target($urandom, $urandom);
        repeat (40) send_fix(random_fix());
    endtask

    // back-to-back stretch with no idling on either side
    task automatic test_full_rate;
        set_target($urandom_range(0, 2 * LAT_MAX) - LAT_MAX,
                   int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        no_idle = 1'b1;
        repeat (150) send_fix(random_fix());
        no_idle = 1'b0;
    endtask

    // random fixes; the sender once waits for the pipeline to empty
    task automatic test_random;
        for (int p = 0; p < 6; p++) begin
            set_target($urandom_range(0, 2 * LAT_MAX) - LAT_MAX,
                       int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
            for (int n = 0; n < 250; n++) begin
                if (p == 2 && n == 125) begin
                    i_valid = 1'b0;
                    while (bearing_q.size() != 0) @(negedge i_clk);
                end
                send_fix(random_fix());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tgt_lat = '0;
        tgt_lon = '0;
        mismatches = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_targets();
        test_full_rate();
        test_random();

        // let everything drain, the watchdog covers a hang
        i_valid = 1'b0;
        while (bearing_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
